[rtl/prmt_pkg.sv]
// Shared types, constants and helpers for the prefix rule match table.
// Used by prmt_rule_ram, prmt_seq and prefix_rule_match_table_top.
package prmt_pkg;

  localparam int ADDR_W   = 32;
  localparam int CAP      = 64;
  localparam int IDX_W    = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CNT_W    = $clog2(CAP + 1);
  localparam int LEN_W    = 6;

  // Stream packing
  localparam int S_DATA_W = 40;  // address_bits, prefix_length, zero pad
  localparam int S_USER_W = 1;   // cmd
  localparam int M_DATA_W = 8;   // hit, table_full, zero pad
  localparam int ADDR_LSB = 0;
  localparam int LEN_LSB  = ADDR_W;

  // Request kinds carried on s_tuser
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] prefix;
  } rule_entry_t;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    rule_entry_t       wr_entry;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
  } ram_req_t;

  typedef struct packed {
    logic table_full;
    logic hit;
  } result_t;

  // Keep the leading len bits of an address, most significant bit first.
  function automatic logic [ADDR_W-1:0] lead_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len == '0) begin
      m = '0;
    end else begin
      m = {ADDR_W{1'b1}} << (ADDR_W - int'(len));
    end
    return m;
  endfunction

endpackage

[rtl/prmt_rule_ram.sv]
// Rule store: one synchronous memory of prefix and length per entry.
// Depends on prmt_pkg for the entry and request types.
module prmt_rule_ram (
  input  logic                 clk,
  input  prmt_pkg::ram_req_t   req,
  output prmt_pkg::rule_entry_t rd_entry
);
  import prmt_pkg::*;

  rule_entry_t mem [CAP];

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_entry;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_entry <= mem[req.rd_addr];
    end
  end

endmodule

[rtl/prmt_seq.sv]
// Request sequencer: appends rules and walks the stored rules for a lookup.
// Depends on prmt_pkg; drives the prmt_rule_ram request port.
module prmt_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [prmt_pkg::S_DATA_W-1:0]     s_tdata,
  input  logic [prmt_pkg::S_USER_W-1:0]     s_tuser,
  input  prmt_pkg::rule_entry_t             rd_entry,
  output prmt_pkg::ram_req_t                ram_req,
  input  logic                              out_free,
  output logic                              res_valid,
  output prmt_pkg::result_t                 res
);
  import prmt_pkg::*;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [IDX_W-1:0]   scan_idx, scan_idx_next;
  logic [ADDR_W-1:0]  addr_q, addr_next;
  result_t            res_next;

  logic [ADDR_W-1:0]  in_addr;
  logic [LEN_W-1:0]   in_len, len_sat;
  logic [ADDR_W-1:0]  rule_mask;
  logic               rule_hit;
  logic               last_rule;

  // Unpack request and saturate an overlong length
  assign in_addr = s_tdata[ADDR_LSB +: ADDR_W];
  assign in_len  = s_tdata[LEN_LSB +: LEN_W];
  assign len_sat = (in_len > LEN_W'(ADDR_W)) ? LEN_W'(ADDR_W) : in_len;

  // Compare the rule read last cycle against the held address
  assign rule_mask = lead_mask(rd_entry.len);
  assign rule_hit  = ((addr_q & rule_mask) == rd_entry.prefix);
  assign last_rule = ((CNT_W'(scan_idx) + CNT_W'(1)) == count);

  assign res_valid = (state == ST_DONE);

  // State, count and scan registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      scan_idx <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      scan_idx <= scan_idx_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr_q <= addr_next;
    res    <= res_next;
  end

  // Next state, memory requests and result.
  // An insert writes in its accept cycle; no lookup can be accepted in that
  // same cycle, so a read never collides with a write to the same entry.
  always_comb begin
    state_next       = state;
    count_next       = count;
    scan_idx_next    = scan_idx;
    addr_next        = addr_q;
    res_next         = res;
    s_tready         = 1'b0;
    ram_req.wr_en    = 1'b0;
    ram_req.wr_addr  = count[IDX_W-1:0];
    ram_req.wr_entry.len    = len_sat;
    ram_req.wr_entry.prefix = in_addr & lead_mask(len_sat);
    ram_req.rd_en    = 1'b0;
    ram_req.rd_addr  = '0;

    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          addr_next     = in_addr;
          scan_idx_next = '0;
          res_next      = '0;
          if (s_tuser[0] == CMD_INSERT) begin
            // Append the rule or flag a full store
            if (count == CNT_W'(CAP)) begin
              res_next.table_full = 1'b1;
            end else begin
              ram_req.wr_en = 1'b1;
              count_next    = count + CNT_W'(1);
            end
            state_next = ST_DONE;
          end else if (count == '0) begin
            state_next = ST_DONE;
          end else begin
            // Fetch the first rule
            ram_req.rd_en = 1'b1;
            state_next    = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (rule_hit) begin
          res_next.hit = 1'b1;
          state_next   = ST_DONE;
        end else if (last_rule) begin
          state_next = ST_DONE;
        end else begin
          // Advance to the next rule
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = scan_idx + IDX_W'(1);
          scan_idx_next   = scan_idx + IDX_W'(1);
        end
      end

      ST_DONE: begin
        // Hold the result until the output register frees up
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/prefix_rule_match_table_top.sv]
// Prefix rule match table: stores up to CAP address prefix rules and
// answers whether an address matches any of them.
// Depends on prmt_pkg, prmt_rule_ram and prmt_seq.
//
// Input channel s_*: one request per handshake. s_tuser carries the kind
// (insert or lookup); s_tdata carries the address or rule bits and the rule
// length. Output channel m_*: one result per request, in request order.
// An insert stores the rule at the next free entry, or drops it and flags
// table_full when the store holds CAP rules. A lookup reads the stored rules
// one per cycle from the rule memory and stops at the first match.
// Path, accept to result in the output register: an insert or a lookup on an
//   empty store goes from ST_IDLE to ST_DONE; a lookup scans in ST_SCAN,
//   reading rules up to the first match (at most the rule count) through
//   the single read port of the rule memory, then enters ST_DONE, which
//   holds the result until the output register is free.
// A new request is taken once the previous result sits in the output
// register, even while the receiver still stalls it; a stalled result holds
// m_tvalid and m_tdata until taken. Reset empties the store (rule count 0)
// and drops any pending result; the memory contents need no clearing.
module prefix_rule_match_table_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [31:0] address_bits, [37:32] prefix_length, [39:38] zero
  input  logic [prmt_pkg::S_DATA_W-1:0]  s_tdata,
  // [0] cmd
  input  logic [prmt_pkg::S_USER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] hit, [1] table_full, [7:2] zero
  output logic [prmt_pkg::M_DATA_W-1:0]  m_tdata
);
  import prmt_pkg::*;

  ram_req_t     ram_req;
  rule_entry_t  rd_entry;
  logic         out_free;
  logic         res_valid;
  result_t      res;
  result_t      out_res;

  prmt_rule_ram u_ram (
    .clk      (clk),
    .req      (ram_req),
    .rd_entry (rd_entry)
  );

  prmt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .rd_entry  (rd_entry),
    .ram_req   (ram_req),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_free = !m_tvalid || m_tready;

  // Output register: load a finished result, hold it while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {{(M_DATA_W - 2){1'b0}}, out_res.table_full, out_res.hit};

endmodule

[verif/prefix_rule_match_table_top_tb.sv]
// Self-checking testbench for prefix_rule_match_table_top: inserts address prefix rules,
// looks up addresses and checks each hit / table_full result against an in-bench predictor.
// Depends on prmt_pkg and the prefix_rule_match_table_top RTL.
`timescale 1ns / 1ps

module prefix_rule_match_table_top_tb;
  import prmt_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 5;
  localparam int RANDOM_ITEMS   = 830;
  localparam int FILL_START     = 650;   // from here inserts are forced until the store is full
  localparam int HOLD_AT_ITEM   = 200;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = CAP + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PAD_W          = S_DATA_W - LEN_W - ADDR_W;

  typedef struct {
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    bit                typed;
    logic              hit;
    logic              table_full;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [S_USER_W-1:0] s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  // Predictor state: rules as the block should hold them
  logic [ADDR_W-1:0] held_prefix [CAP];
  int                held_len    [CAP];
  int                held_count = 0;

  result_t   pending_results[$];
  plan_row_t directed_plan[$];
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  bit        burst_phase = 1'b0;
  bit        hold_output = 1'b0;

  prefix_rule_match_table_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mask keeping the leading bits bits of an address, MSB first
  function automatic logic [ADDR_W-1:0] keep_mask(input int bits);
    logic [ADDR_W-1:0] ones;
    ones = '1;
    return ~(ones >> bits);
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Apply one accepted request to the predicted store and work out its result
  task automatic classify_request(input logic cmd, input logic [ADDR_W-1:0] addr,
                                  input logic [LEN_W-1:0] len, output result_t res);
    int fixed_bits;
    res = '0;
    fixed_bits = (int'(len) > ADDR_W) ? ADDR_W : int'(len);
    if (cmd == CMD_INSERT) begin
      if (held_count >= CAP) begin
        res.table_full = 1'b1;
      end else begin
        held_prefix[held_count] = addr & keep_mask(fixed_bits);
        held_len[held_count] = fixed_bits;
        held_count++;
      end
    end else begin
      for (int i = 0; i < held_count; i++) begin
        if (((addr ^ held_prefix[i]) & keep_mask(held_len[i])) == '0) res.hit = 1'b1;
      end
    end
  endtask

  task automatic add_row(input logic cmd, input logic [ADDR_W-1:0] addr,
                         input logic [LEN_W-1:0] len, input bit typed,
                         input logic hit, input logic table_full);
    plan_row_t row;
    row.cmd = cmd;
    row.addr = addr;
    row.len = len;
    row.typed = typed;
    row.hit = hit;
    row.table_full = table_full;
    directed_plan.push_back(row);
  endtask

  // Offer one request, hold it until taken, then record its expected result
  task automatic offer_request(input logic cmd, input logic [ADDR_W-1:0] addr,
                               input logic [LEN_W-1:0] len, input bit typed,
                               input logic typed_hit, input logic typed_full);
    int      gap;
    result_t want;
    gap = burst_phase ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {{PAD_W{1'b0}}, len, addr};
    do @(posedge clk); while (!s_tready);
    classify_request(cmd, addr, len, want);
    if (typed) begin
      want.hit = typed_hit;
      want.table_full = typed_full;
    end
    pending_results.push_back(want);
  endtask

  // Stimulus: directed table, then random requests that fill the store
  initial begin : stimulus
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    bit                want_insert;
    int                idx;
    int                roll;

    // empty store, exact rules, overlong lengths, short prefixes, duplicates
    add_row(CMD_LOOKUP, 32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b0);
    add_row(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, 1'b0);
    add_row(CMD_INSERT, 32'hFFFF_FFFF, 6'd32, 1'b1, 1'b0, 1'b0);
    add_row(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0,  1'b0, 1'b0, 1'b0);
    add_row(CMD_LOOKUP, 32'hFFFF_FFFE, 6'd0,  1'b0, 1'b0, 1'b0);
    add_row(CMD_INSERT, 32'h0000_0000, 6'd63, 1'b1, 1'b0, 1'b0);
    add_row(CMD_LOOKUP, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 1'b0);
    add_row(CMD_LOOKUP, 32'h0000_0001, 6'd0,  1'b0, 1'b0, 1'b0);
    add_row(CMD_INSERT, 32'hC0A8_0000, 6'd16, 1'b1, 1'b0, 1'b0);
    add_row(CMD_LOOKUP, 32'hC0A8_FFFF, 6'd0,  1'b0, 1'b0, 1'b0);
    add_row(CMD_LOOKUP, 32'hC0A9_0000, 6'd0,  1'b0, 1'b0, 1'b0);
    add_row(CMD_INSERT, 32'h8000_0000, 6'd1,  1'b1, 1'b0, 1'b0);
    add_row(CMD_LOOKUP, 32'h8000_0000, 6'd0,  1'b0, 1'b0, 1'b0);
    add_row(CMD_LOOKUP, 32'h7FFF_FFFF, 6'd0,  1'b0, 1'b0, 1'b0);
    add_row(CMD_INSERT, 32'h1234_5678, 6'd33, 1'b1, 1'b0, 1'b0);
    add_row(CMD_LOOKUP, 32'h1234_5678, 6'd0,  1'b0, 1'b0, 1'b0);
    add_row(CMD_LOOKUP, 32'h1234_5679, 6'd0,  1'b0, 1'b0, 1'b0);
    add_row(CMD_INSERT, 32'h2BCD_EF01, 6'd24, 1'b1, 1'b0, 1'b0);
    add_row(CMD_LOOKUP, 32'h2BCD_EF99, 6'd0,  1'b0, 1'b0, 1'b0);
    add_row(CMD_LOOKUP, 32'h2BCC_EF01, 6'd0,  1'b0, 1'b0, 1'b0);
    add_row(CMD_INSERT, 32'hC0A8_0000, 6'd16, 1'b1, 1'b0, 1'b0);
    add_row(CMD_LOOKUP, 32'hC0A8_1234, 6'd0,  1'b0, 1'b0, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      offer_request(directed_plan[i].cmd, directed_plan[i].addr, directed_plan[i].len,
                    directed_plan[i].typed, directed_plan[i].hit,
                    directed_plan[i].table_full);
    end

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      burst_phase = (k % 150) < 25;
      if (k == HOLD_AT_ITEM) hold_output = 1'b1;

      // keep the last free entry for the match-all rule until late in the run
      if (held_count < CAP - 1) begin
        want_insert = (k >= FILL_START) || ($urandom_range(0, 99) < 12);
      end else if (held_count == CAP - 1) begin
        want_insert = (k >= FILL_START);
      end else begin
        want_insert = ($urandom_range(0, 99) < 30);
      end

      addr = $urandom;
      if (want_insert) begin
        cmd = CMD_INSERT;
        roll = $urandom_range(0, 99);
        if (held_count == CAP - 1) begin
          len = '0;
        end else if (roll < 6) begin
          len = LEN_W'($urandom_range(1, 11));
        end else if (roll < 80) begin
          len = LEN_W'($urandom_range(12, ADDR_W));
        end else begin
          len = LEN_W'($urandom_range(ADDR_W + 1, 63));
        end
      end else begin
        cmd = CMD_LOOKUP;
        len = LEN_W'($urandom);
        // half the lookups aim at a stored rule, some with one bit flipped
        if (held_count > 0 && $urandom_range(0, 1) == 1) begin
          idx = $urandom_range(0, held_count - 1);
          addr = held_prefix[idx] | (addr & ~keep_mask(held_len[idx]));
          if ($urandom_range(0, 1) == 1) addr = addr ^ (32'h1 << $urandom_range(0, ADDR_W - 1));
        end
      end
      offer_request(cmd, addr, len, 1'b0, 1'b0, 1'b0);
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off on request
  initial begin : receiver
    int gap;
    repeat (RESET_CYCLES) @(posedge clk);
    forever begin
      if (hold_output) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_output = 1'b0;
      end
      gap = burst_phase ? 0 : pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: tdata %h", m_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[0] !== want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, m_tdata[0]);
          mismatch_count++;
        end
        if (m_tdata[1] !== want.table_full) begin
          $error("table_full: expected %0d, actual %0d", want.table_full, m_tdata[1]);
          mismatch_count++;
        end
        if (m_tdata[M_DATA_W-1:2] !== '0) begin
          $error("pad: expected 0, actual %h", m_tdata[M_DATA_W-1:2]);
          mismatch_count++;
        end
      end
    end
  end

  // Stop the run when no request or result moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
